### design/ascii_coordinate_frame_parser_top_macros.svh
// Assertion macros shared by the coordinate frame parser RTL.
`ifndef ASCII_COORDINATE_FRAME_PARSER_TOP_MACROS_SVH
`define ASCII_COORDINATE_FRAME_PARSER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define ACFP_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("acfp assertion failed");
`define ACFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("acfp assertion failed");
`else
`define ACFP_ASSERT_SAME(label, clk, rst, ante, cons)
`define ACFP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### design/acfp_pkg.sv
// Types, frame symbols, position codes and digit arithmetic for the frame parser.
package acfp_pkg;

  typedef logic [7:0]         byte_t;
  typedef logic signed [15:0] coord_t;
  typedef logic [3:0]         pos_t;

  typedef struct packed {
    logic   emit;
    coord_t x;
    coord_t y;
  } frame_result_t;

  localparam byte_t SYM_START = 8'd35;
  localparam byte_t SYM_SEP   = 8'd42;
  localparam byte_t SYM_END   = 8'd38;

  localparam coord_t DIGIT_BIAS      = 16'sd48;
  localparam coord_t WEIGHT_HUNDREDS = 16'sd100;
  localparam coord_t WEIGHT_TENS     = 16'sd10;

  localparam int NUM_DIGITS = 6;

  localparam pos_t POS_IDLE   = 4'd0;
  localparam pos_t POS_START  = 4'd1;
  localparam pos_t POS_DIGIT0 = 4'd2;
  localparam pos_t POS_DIGIT5 = 4'd7;
  localparam pos_t POS_SEP2   = 4'd8;
  localparam pos_t POS_END    = 4'd9;

  function automatic coord_t digit_value(byte_t b);
    coord_t v;
    v = coord_t'({{8{b[7]}}, b}) - DIGIT_BIAS;
    return v;
  endfunction

  function automatic coord_t combine(byte_t h, byte_t t, byte_t u);
    coord_t sum;
    sum = digit_value(h) * WEIGHT_HUNDREDS + digit_value(t) * WEIGHT_TENS
        + digit_value(u);
    return sum;
  endfunction

endpackage

### design/acfp_frame_fsm.sv
// Frame position tracker, digit registers and coordinate combine.
`include "ascii_coordinate_frame_parser_top_macros.svh"

module acfp_frame_fsm (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  acfp_pkg::byte_t       rx_byte,
  output acfp_pkg::frame_result_t res,
  output logic                  at_end
);
  import acfp_pkg::*;

  pos_t  pos;
  pos_t  pos_next;
  byte_t digits [NUM_DIGITS];

  always_comb begin
    pos_next = POS_IDLE;
    unique case (pos) inside
      POS_IDLE:  pos_next = (rx_byte == SYM_START) ? POS_START : POS_IDLE;
      POS_START: pos_next = (rx_byte == SYM_SEP) ? POS_DIGIT0 : POS_IDLE;
      [POS_DIGIT0:POS_DIGIT5]: pos_next = pos + 4'd1;
      POS_SEP2:  pos_next = (rx_byte == SYM_SEP) ? POS_END : POS_IDLE;
      default:   pos_next = POS_IDLE;
    endcase
    // '&' anywhere drops the frame (or closes it at the last position)
    if (rx_byte == SYM_END) begin
      pos_next = POS_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_IDLE;
    end else if (accept) begin
      pos <= pos_next;
    end
  end

  // each digit register is loaded only at its own frame position
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (accept && pos == POS_DIGIT0 + pos_t'(i)) begin
        digits[i] <= rx_byte;
      end
    end
  end

  assign at_end   = (pos == POS_END);
  assign res.emit = accept && at_end && (rx_byte == SYM_END);
  assign res.x    = combine(digits[0], digits[1], digits[2]);
  assign res.y    = combine(digits[3], digits[4], digits[5]);

  `ACFP_ASSERT_NEXT(a_end_byte_idles, clk, rst, accept && rx_byte == SYM_END, pos == POS_IDLE)
  `ACFP_ASSERT_NEXT(a_last_pos_idles, clk, rst, accept && at_end, pos == POS_IDLE)
  `ACFP_ASSERT_SAME(a_pos_in_range, clk, rst, 1'b1, pos <= POS_END && pos <= POS_DIGIT5 + 4'd2)

endmodule

### design/ascii_coordinate_frame_parser_top.sv
// A result beat is registered into the result queue as the closing '&' beat is taken.
// Throughput: one byte per cycle; input stalls only while two result beats are
// queued and the frame sits at its closing position (set by the 2-entry result queue).
// Reset (rst, synchronous): frame position returns to waiting for '#', queue empties;
// digit registers are not reset and are always written before a frame can complete.
`include "ascii_coordinate_frame_parser_top_macros.svh"

module ascii_coordinate_frame_parser_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  acfp_pkg::byte_t      rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output acfp_pkg::coord_t     x_coord,
  output acfp_pkg::coord_t     y_coord
);
  import acfp_pkg::*;

  frame_result_t res;
  logic          at_end;
  logic          accept;
  logic          push;
  logic          pop;
  logic [1:0]    count;
  coord_t        skid_x;
  coord_t        skid_y;

  // queue full only matters when the next beat might close a frame
  assign in_stall = (count == 2'd2) && at_end;
  assign accept   = in_valid && !in_stall;

  acfp_frame_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .res     (res),
    .at_end  (at_end)
  );

  assign push      = res.emit;
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // head slot drives the ports, second slot catches a beat behind a stalled head
  always_ff @(posedge clk) begin
    case (count)
      2'd0: begin
        if (push) begin
          x_coord <= res.x;
          y_coord <= res.y;
        end
      end
      2'd1: begin
        if (push && pop) begin
          x_coord <= res.x;
          y_coord <= res.y;
        end else if (push) begin
          skid_x <= res.x;
          skid_y <= res.y;
        end
      end
      default: begin
        if (pop) begin
          x_coord <= skid_x;
          y_coord <= skid_y;
        end
      end
    endcase
  end

  `ACFP_ASSERT_SAME(a_no_overflow, clk, rst, push, count != 2'd2)
  `ACFP_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count != 2'd3)
  `ACFP_ASSERT_NEXT(a_drain_empty, clk, rst, pop && count == 2'd1 && !push, !out_valid)

endmodule

### tb/tb_ascii_coordinate_frame_parser_top.sv
// Self-checking testbench for the ASCII coordinate frame parser.
module tb_ascii_coordinate_frame_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  import acfp_pkg::*;

  localparam int ITEMS_TOTAL = 1250;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 10;
  localparam byte_t ASCII_ZERO = "0";

  // Expected-coordinate tracker: follows the frame state per accepted beat.
  class coord_scoreboard;
    typedef struct {
      coord_t x;
      coord_t y;
    } coord_pair_t;

    coord_pair_t pending_q[$];
    pos_t        pos;
    byte_t       digits[NUM_DIGITS];
    int          errors;

    function new();
      clear_frame();
      errors = 0;
    endfunction

    function void clear_frame();
      pos = POS_IDLE;
      foreach (digits[i]) digits[i] = '0;
    endfunction

    // Digits are signed bytes less the ASCII bias; result wraps to 16 bits.
    function coord_t weigh(byte_t h, byte_t t, byte_t u);
      int sum;
      sum = (int'($signed(h)) - int'(DIGIT_BIAS)) * int'(WEIGHT_HUNDREDS)
          + (int'($signed(t)) - int'(DIGIT_BIAS)) * int'(WEIGHT_TENS)
          + (int'($signed(u)) - int'(DIGIT_BIAS));
      return coord_t'(sum[15:0]);
    endfunction

    function void note_beat(byte_t b);
      coord_pair_t pair;
      if (pos == POS_IDLE && b == SYM_START) begin
        pos = POS_START;
      end else if (pos == POS_START && b == SYM_SEP) begin
        pos = POS_DIGIT0;
      end else if (pos >= POS_DIGIT0 && pos <= POS_DIGIT5) begin
        digits[3'(pos - POS_DIGIT0)] = b;
        pos = pos + 1'b1;
      end else if (pos == POS_SEP2 && b == SYM_SEP) begin
        pos = POS_END;
      end else if (pos == POS_END && b == SYM_END) begin
        pair.x = weigh(digits[0], digits[1], digits[2]);
        pair.y = weigh(digits[3], digits[4], digits[5]);
        pending_q.push_back(pair);
        pos = POS_IDLE;
      end else begin
        clear_frame();
      end
      // '&' always resets, even right after a digit was stored
      if (b == SYM_END) clear_frame();
    endfunction

    task report_mismatch(string what);
      $display("%0t ns mismatch: %s", $time, what);
      errors++;
    endtask

    task check_result(coord_t x, coord_t y);
      coord_pair_t exp_pair;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result x=%0d y=%0d", x, y));
      end else begin
        exp_pair = pending_q.pop_front();
        if (x !== exp_pair.x)
          report_mismatch($sformatf("x_coord %0d, want %0d", x, exp_pair.x));
        if (y !== exp_pair.y)
          report_mismatch($sformatf("y_coord %0d, want %0d", y, exp_pair.y));
      end
    endtask

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_stall;
  byte_t  rx_byte = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  coord_t x_coord;
  coord_t y_coord;

  int idle_pct = 0;
  int stall_pct = 0;
  int sent = 0;
  int cycle_count = 0;

  coord_scoreboard sb = new();

  ascii_coordinate_frame_parser_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .x_coord   (x_coord),
    .y_coord   (y_coord)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_ascii_coordinate_frame_parser_top: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(x_coord, y_coord);
  end

  // Called at a clock edge; returns at the edge where the beat is taken.
  task automatic send_byte(byte_t b);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_beat(b);
    sent++;
  endtask

  initial begin
    byte_t directed_q[$];
    byte_t frm[10];
    byte_t expected_sym;
    int    rnd_base;
    int    phase;
    int    kind;
    int    cut;

    // max/min coordinates, doubled '#', '&' on a digit, '&' after '#',
    // wrong closing byte with 0x00 digits, plus stray bytes while waiting
    directed_q = '{8'h00, 8'hFF,
                   SYM_START, SYM_SEP, 8'h7F, 8'h7F, 8'h7F, 8'h80, 8'h80, 8'h80,
                   SYM_SEP, SYM_END,
                   SYM_START, SYM_START, SYM_SEP,
                   SYM_START, SYM_SEP, 8'h39, SYM_END,
                   SYM_START, SYM_END,
                   SYM_START, SYM_SEP, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                   SYM_SEP, SYM_SEP};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_q[i]) send_byte(directed_q[i]);

    rnd_base = sent;
    while (sent - rnd_base < ITEMS_TOTAL) begin
      // no idling, sender idle, receiver stalling, then both
      phase = ((sent - rnd_base) * 4) / ITEMS_TOTAL;
      idle_pct  = (phase == 1) ? 84 : (phase == 3) ? 31 : 0;
      stall_pct = (phase == 2) ? 84 : (phase == 3) ? 31 : 0;

      frm[0] = SYM_START;
      frm[1] = SYM_SEP;
      for (int i = 2; i < 8; i++) begin
        if ($urandom_range(99) < 80) frm[i] = ASCII_ZERO + byte_t'($urandom_range(9));
        else frm[i] = byte_t'($urandom_range(255));
      end
      frm[8] = SYM_SEP;
      frm[9] = SYM_END;

      kind = $urandom_range(99);
      if (kind < 70) begin
        foreach (frm[i]) send_byte(frm[i]);
      end else if (kind < 88) begin
        // broken frame: corrupt one position and end the frame at that byte
        cut = $urandom_range(9);
        if (cut >= 2 && cut <= 7) begin
          frm[cut] = SYM_END;
        end else begin
          expected_sym = frm[cut];
          if (cut != 9 && $urandom_range(99) < 30) begin
            frm[cut] = SYM_END;
          end else begin
            do frm[cut] = byte_t'($urandom_range(255));
            while (frm[cut] == expected_sym || frm[cut] == SYM_END);
          end
        end
        for (int i = 0; i <= cut; i++) send_byte(frm[i]);
      end else begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(3))
            0: send_byte(SYM_START);
            1: send_byte(SYM_SEP);
            2: send_byte(SYM_END);
            default: send_byte(byte_t'($urandom_range(255)));
          endcase
        end
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_ascii_coordinate_frame_parser_top: clean");
    end else begin
      $display("tb_ascii_coordinate_frame_parser_top: errors");
    end
    $finish;
  end

endmodule
